[rtl/mbe_pkg.sv]
// Package for the Mandelbrot escape-time counter.
// Holds shared widths, defaults and the controller/datapath interface structs.
// No dependencies.
package mbe_pkg;

  localparam int IN_W = 24;
  localparam int CNT_W = 4;
  localparam int FRAC_BITS_DEF = 20;
  localparam int ITER_LIMIT_DEF = 15;
  localparam int ESCAPE_RADIUS_SQ = 4;
  localparam logic [CNT_W-1:0] MAX_ITER_RESET = CNT_W'(10);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mul;
    logic update;
  } mbe_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic zero_limit;
    logic escape;
    logic last;
  } mbe_status_t;

endpackage

[rtl/mbe_ctrl.sv]
// Controller state machine for the escape-time counter.
// Sequences load, multiply and update steps; depends on mbe_pkg.
module mbe_ctrl import mbe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  mbe_status_t status,
  output mbe_cmd_t    cmd,
  output logic        busy,
  output logic        done
);

  typedef enum logic [1:0] {
    IDLE,
    MUL,
    UPD
  } state_t;

  state_t state;

  assign busy = (state != IDLE);

  always_comb begin
    cmd.load = (state == IDLE) && start;
    cmd.mul = (state == MUL);
    cmd.update = (state == UPD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        IDLE: begin
          if (start) begin
            // A zero limit runs no iteration and reports at once.
            if (status.zero_limit) begin
              done <= 1'b1;
            end else begin
              state <= MUL;
            end
          end
        end
        MUL: begin
          state <= UPD;
        end
        UPD: begin
          if (status.escape || status.last) begin
            done <= 1'b1;
            state <= IDLE;
          end else begin
            state <= MUL;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/mbe_datapath.sv]
// Datapath for the escape-time counter: z registers, shared multipliers,
// escape test, iteration counter and limit register; depends on mbe_pkg.
module mbe_datapath import mbe_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int ITER_LIMIT = ITER_LIMIT_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  mbe_cmd_t                cmd,
  output mbe_status_t             status,
  input  logic                    cfg_we,
  input  logic [CNT_W-1:0]        cfg_data,
  input  logic signed [IN_W-1:0]  c_re,
  input  logic signed [IN_W-1:0]  c_im,
  output logic [CNT_W-1:0]        iteration_count,
  output logic                    bounded
);

  // z stays within radius 2 while iterating, so one step reaches at most
  // 4 plus the largest |c|; two guard bits above that cover the sign.
  localparam int ZW = (((FRAC_BITS + 3) > (IN_W - 1)) ? (FRAC_BITS + 3) : (IN_W - 1)) + 2;
  localparam int PW = 2 * ZW;
  localparam logic [PW:0] THR = (PW + 1)'(ESCAPE_RADIUS_SQ) << (2 * FRAC_BITS);

  logic [CNT_W-1:0]       max_iterations;
  logic [CNT_W-1:0]       limit;
  logic [CNT_W-1:0]       limit_next;
  logic [CNT_W-1:0]       iter_inc;
  logic signed [IN_W-1:0] cr;
  logic signed [IN_W-1:0] ci;
  logic signed [ZW-1:0]   x;
  logic signed [ZW-1:0]   y;
  logic signed [ZW-1:0]   x_next;
  logic signed [ZW-1:0]   y_next;
  logic signed [PW-1:0]   xx;
  logic signed [PW-1:0]   yy;
  logic signed [PW-1:0]   xy;
  logic [PW:0]            mag_sq;
  logic signed [PW:0]     diff;
  logic signed [PW:0]     diff_sh;
  logic signed [PW-1:0]   xy_sh;

  always_comb begin
    if (32'(max_iterations) > ITER_LIMIT) begin
      limit_next = CNT_W'(ITER_LIMIT);
    end else begin
      limit_next = max_iterations;
    end
  end

  assign iter_inc = iteration_count + CNT_W'(1);

  always_comb begin
    mag_sq = {1'b0, $unsigned(xx)} + {1'b0, $unsigned(yy)};
    diff = (PW + 1)'(xx) - (PW + 1)'(yy);
    diff_sh = diff >>> FRAC_BITS;
    xy_sh = xy >>> (FRAC_BITS - 1);
    x_next = ZW'(diff_sh) + ZW'(cr);
    y_next = ZW'(xy_sh) + ZW'(ci);
  end

  assign status.zero_limit = (limit_next == '0);
  assign status.escape = (mag_sq > THR);
  assign status.last = (iter_inc == limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations <= MAX_ITER_RESET;
    end else if (cfg_we) begin
      max_iterations <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cr <= c_re;
      ci <= c_im;
      x <= '0;
      y <= '0;
      limit <= limit_next;
      iteration_count <= '0;
      bounded <= status.zero_limit;
    end
    if (cmd.mul) begin
      xx <= x * x;
      yy <= y * y;
      xy <= x * y;
    end
    if (cmd.update) begin
      bounded <= !status.escape && status.last;
      if (!status.escape) begin
        x <= x_next;
        y <= y_next;
        iteration_count <= iter_inc;
      end
    end
  end

endmodule

[rtl/mandelbrot_escape_count.sv]
// Top level of the Mandelbrot escape-time counter.
// Joins mbe_ctrl and mbe_datapath; depends on mbe_pkg.
//
//   channel  signals                        direction  handshake
//   input    start, busy, c_re, c_im        in         start & !busy
//   result   done, iteration_count, bounded out        done, one cycle
//   config   cfg_we, cfg_data               in         cfg_we
//
// Each iteration has two steps: the MUL state registers x*x, y*y and x*y
// in the shared multipliers, and the UPD state tests the escape radius and
// updates z. An item loads c and then runs up to the limit of iterations
// (the default limit is ten); a zero limit answers at once. Reset clears the
// state machine and loads the limit register with ten. The receiver cannot
// stall: done is high for one cycle and the next item may start in it.
module mandelbrot_escape_count import mbe_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int ITER_LIMIT = ITER_LIMIT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [IN_W-1:0] c_re,
  input  logic signed [IN_W-1:0] c_im,
  output logic                   done,
  output logic [CNT_W-1:0]       iteration_count,
  output logic                   bounded,
  input  logic                   cfg_we,
  input  logic [CNT_W-1:0]       cfg_data
);

  mbe_cmd_t    cmd;
  mbe_status_t status;

  mbe_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  mbe_datapath #(
    .FRAC_BITS  (FRAC_BITS),
    .ITER_LIMIT (ITER_LIMIT)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .c_re            (c_re),
    .c_im            (c_im),
    .iteration_count (iteration_count),
    .bounded         (bounded)
  );

  // A result is only reported once the sequencer is back in idle.
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // The origin never escapes, so an escaped point has done at least one iteration.
  assert property (@(posedge clk) disable iff (rst)
    (done && !bounded) |-> (iteration_count != '0))
    else $error("escape reported with zero iterations");

  // An accepted item either starts work or answers at once.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted item was dropped");

  // Work only begins on an accepted item.
  assert property (@(posedge clk) disable iff (rst) $rose(busy) |-> $past(start))
    else $error("busy without a start");

endmodule
